### rtl/text_console_char_engine_core_assert.svh
// Assertion helpers for the console engine. The clock and reset in scope at
// the point of use are clk and rst.
`ifndef TEXT_CONSOLE_CHAR_ENGINE_CORE_ASSERT_SVH
`define TEXT_CONSOLE_CHAR_ENGINE_CORE_ASSERT_SVH

// Condition holds at every clock edge outside reset.
`define TCCE_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define TCCE_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

### rtl/tcce_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tcce_pkg;

  // Screen and memory geometry
  localparam int COLUMNS      = 80;
  localparam int ROWS         = 25;
  localparam int MEM_WORDS    = 16384;
  localparam int SCREEN_WORDS = COLUMNS * ROWS;
  localparam int ADDR_W       = $clog2(MEM_WORDS);

  // Field widths
  localparam int POS_W       = 14;
  localparam int COL_W       = 7;
  localparam int ROW_W       = 5;
  localparam int CELL_W      = 16;
  localparam int ATTR_W      = 8;
  localparam int CHAR_W      = 8;
  localparam int REQ_W       = 2;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 48;

  localparam logic [ATTR_W-1:0] ATTR_RESET  = 8'h07;
  localparam logic [CELL_W-1:0] BLANK_RESET = 16'h0720;

  // Control characters
  localparam logic [CHAR_W-1:0] CH_NUL = 8'h00;
  localparam logic [CHAR_W-1:0] CH_ENQ = 8'h05;
  localparam logic [CHAR_W-1:0] CH_BEL = 8'h07;
  localparam logic [CHAR_W-1:0] CH_BS  = 8'h08;
  localparam logic [CHAR_W-1:0] CH_HT  = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF  = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_VT  = 8'h0B;
  localparam logic [CHAR_W-1:0] CH_FF  = 8'h0C;
  localparam logic [CHAR_W-1:0] CH_CR  = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_DEL = 8'h7F;

  typedef enum logic [REQ_W-1:0] {
    REQ_WRITE = 2'd0,
    REQ_CLEAR = 2'd1,
    REQ_READ  = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_CHAR_ATTRIBUTE = 1'b0,
    CFG_BLANK_CELL     = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_BLANK_CUR,
    WR_BLANK_PREV,
    WR_CHAR_CUR,
    WR_BLANK_IDX,
    WR_BLANK_SCROLL
  } wr_sel_t;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_OFFSET,
    RD_COPY
  } rd_sel_t;

  typedef enum logic [3:0] {
    POS_HOLD,
    POS_BACK,
    POS_CR,
    POS_WRAP,
    POS_ROW,
    POS_REBASE,
    POS_SCROLL,
    POS_PUT,
    POS_CLEAR
  } pos_op_t;

  typedef enum logic [1:0] {
    IDX_HOLD,
    IDX_ZERO,
    IDX_INC
  } idx_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_NEWLINE,
    ST_COPY,
    ST_COPY_END,
    ST_SCROLL,
    ST_PUT,
    ST_CLEAR,
    ST_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic    load_in;
    wr_sel_t wr_sel;
    rd_sel_t rd_sel;
    pos_op_t pos_op;
    idx_op_t idx_op;
    logic    load_out;
  } dp_cmd_t;

  typedef struct packed {
    req_t              req;
    logic [CHAR_W-1:0] ch;
    logic              col_zero;
    logic              col_full;
    logic              last_row;
    logic              need_copy;
    logic              idx_last_mem;
    logic              idx_last_screen;
    logic              idx_last_col;
    logic              copy_pend;
    logic              out_free;
    logic [COL_W-1:0]  column;
    logic [ROW_W-1:0]  row;
  } dp_sts_t;

endpackage
`default_nettype wire

### rtl/tcce_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module tcce_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16384
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### rtl/tcce_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module tcce_dp
  import tcce_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire dp_cmd_t               cmd,
  output dp_sts_t                    sts,
  input  wire logic [REQ_W-1:0]      in_req,
  input  wire logic [CHAR_W-1:0]     in_ch,
  input  wire logic [POS_W-1:0]      in_roff,
  input  wire logic                  in_eow,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  out_ready,
  output logic                       out_valid,
  output logic      [POS_W-1:0]      out_cursor,
  output logic      [POS_W-1:0]      out_screen,
  output logic                       out_publish,
  output logic                       out_beep,
  output logic      [CELL_W-1:0]     out_rdata
);

  function automatic logic [POS_W-1:0] add_wrap(input logic [POS_W-1:0] a,
                                                input logic [POS_W-1:0] b);
    logic [POS_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (POS_W+1)'(MEM_WORDS)) s = s - (POS_W+1)'(MEM_WORDS);
    return s[POS_W-1:0];
  endfunction

  function automatic logic [POS_W-1:0] sub_wrap(input logic [POS_W-1:0] a,
                                                input logic [POS_W-1:0] b);
    logic [POS_W:0] s;
    if (a >= b) s = {1'b0, a} - {1'b0, b};
    else        s = {1'b0, a} + (POS_W+1)'(MEM_WORDS) - {1'b0, b};
    return s[POS_W-1:0];
  endfunction

  // Latched request
  logic [REQ_W-1:0]  req;
  logic [CHAR_W-1:0] ch;
  logic [POS_W-1:0]  roff;
  logic              eow;

  // Configuration
  logic [ATTR_W-1:0] char_attribute;
  logic [CELL_W-1:0] blank_cell;

  // Positions
  logic [COL_W-1:0]  column,      column_next;
  logic [ROW_W-1:0]  row,         row_next;
  logic [POS_W-1:0]  cursor_word, cursor_word_next;
  logic [POS_W-1:0]  screen_word, screen_word_next;

  // Sweep counter and copy pipeline
  logic [ADDR_W-1:0] idx;
  logic [ADDR_W-1:0] copy_idx;
  logic              copy_pend;

  // Memory port signals
  logic              ram_we;
  logic [POS_W-1:0]  ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic              ram_re;
  logic [POS_W-1:0]  ram_raddr;
  logic [CELL_W-1:0] ram_rdata;

  logic [POS_W-1:0]  cursor_prev;
  logic [POS_W-1:0]  scroll_addr;
  logic [POS_W-1:0]  copy_src;
  logic              roff_ok;
  logic              out_free;

  assign cursor_prev = sub_wrap(cursor_word, POS_W'(1));
  assign scroll_addr = add_wrap(add_wrap(screen_word, POS_W'(SCREEN_WORDS)), POS_W'(idx));
  assign copy_src    = add_wrap(screen_word, POS_W'(idx));
  assign roff_ok     = {1'b0, roff} < (POS_W+1)'(MEM_WORDS);
  assign out_free    = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      req  <= in_req;
      ch   <= in_ch;
      roff <= in_roff;
      eow  <= in_eow;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_attribute <= ATTR_RESET;
      blank_cell     <= BLANK_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_CHAR_ATTRIBUTE: char_attribute <= cfg_wdata[ATTR_W-1:0];
        CFG_BLANK_CELL:     blank_cell     <= cfg_wdata[CELL_W-1:0];
      endcase
    end
  end

  always_comb begin
    column_next      = column;
    row_next         = row;
    cursor_word_next = cursor_word;
    screen_word_next = screen_word;
    unique case (cmd.pos_op)
      POS_HOLD: ;
      POS_BACK: begin
        column_next      = column - COL_W'(1);
        cursor_word_next = cursor_prev;
      end
      POS_CR: begin
        column_next      = '0;
        cursor_word_next = sub_wrap(cursor_word, POS_W'(column));
      end
      POS_WRAP: begin
        column_next      = column - COL_W'(COLUMNS);
        cursor_word_next = sub_wrap(cursor_word, POS_W'(COLUMNS));
      end
      POS_ROW: begin
        row_next         = row + ROW_W'(1);
        cursor_word_next = add_wrap(cursor_word, POS_W'(COLUMNS));
      end
      POS_REBASE: begin
        cursor_word_next = sub_wrap(cursor_word, screen_word);
        screen_word_next = '0;
      end
      POS_SCROLL: begin
        screen_word_next = add_wrap(screen_word, POS_W'(COLUMNS));
        cursor_word_next = add_wrap(cursor_word, POS_W'(COLUMNS));
      end
      POS_PUT: begin
        column_next      = column + COL_W'(1);
        cursor_word_next = add_wrap(cursor_word, POS_W'(1));
      end
      POS_CLEAR: begin
        column_next      = '0;
        row_next         = '0;
        cursor_word_next = '0;
        screen_word_next = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column      <= '0;
      row         <= '0;
      cursor_word <= '0;
      screen_word <= '0;
      idx         <= '0;
      copy_pend   <= 1'b0;
    end else begin
      column      <= column_next;
      row         <= row_next;
      cursor_word <= cursor_word_next;
      screen_word <= screen_word_next;
      copy_pend   <= (cmd.rd_sel == RD_COPY);
      case (cmd.idx_op)
        IDX_ZERO: idx <= '0;
        IDX_INC:  idx <= idx + ADDR_W'(1);
        default:  ;
      endcase
    end
  end

  // Destination of the word read in the previous copy cycle
  always_ff @(posedge clk) begin
    copy_idx <= idx;
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cursor_word;
    ram_wdata = blank_cell;
    if (copy_pend) begin
      ram_we    = 1'b1;
      ram_waddr = POS_W'(copy_idx);
      ram_wdata = ram_rdata;
    end else begin
      unique case (cmd.wr_sel)
        WR_NONE: ;
        WR_BLANK_CUR: ram_we = 1'b1;
        WR_BLANK_PREV: begin
          ram_we    = 1'b1;
          ram_waddr = cursor_prev;
        end
        WR_CHAR_CUR: begin
          ram_we    = 1'b1;
          ram_wdata = {char_attribute, ch};
        end
        WR_BLANK_IDX: begin
          ram_we    = 1'b1;
          ram_waddr = POS_W'(idx);
        end
        WR_BLANK_SCROLL: begin
          ram_we    = 1'b1;
          ram_waddr = scroll_addr;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = roff;
    unique case (cmd.rd_sel)
      RD_NONE: ;
      RD_OFFSET: ram_re = roff_ok;
      RD_COPY: begin
        ram_re    = 1'b1;
        ram_raddr = copy_src;
      end
      default: ;
    endcase
  end

  tcce_ram #(
    .WIDTH (CELL_W),
    .DEPTH (MEM_WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr[ADDR_W-1:0]),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_cursor  <= cursor_word;
      out_screen  <= screen_word;
      out_publish <= (req_t'(req) == REQ_WRITE && eow) || req_t'(req) == REQ_CLEAR;
      out_beep    <= req_t'(req) == REQ_WRITE && ch == CH_BEL;
      out_rdata   <= (req_t'(req) == REQ_READ && roff_ok) ? ram_rdata : '0;
    end
  end

  always_comb begin
    sts.req             = req_t'(req);
    sts.ch              = ch;
    sts.col_zero        = column == '0;
    sts.col_full        = column >= COL_W'(COLUMNS);
    sts.last_row        = row >= ROW_W'(ROWS - 1);
    sts.need_copy       = ({1'b0, screen_word} + (POS_W+1)'(SCREEN_WORDS + COLUMNS))
                          >= (POS_W+1)'(MEM_WORDS);
    sts.idx_last_mem    = idx == ADDR_W'(MEM_WORDS - 1);
    sts.idx_last_screen = idx == ADDR_W'(SCREEN_WORDS - 1);
    sts.idx_last_col    = idx == ADDR_W'(COLUMNS - 1);
    sts.copy_pend       = copy_pend;
    sts.out_free        = out_free;
    sts.column          = column;
    sts.row             = row;
  end

endmodule
`default_nettype wire

### rtl/tcce_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module tcce_ctrl
  import tcce_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    s_valid,
  output logic         s_ready,
  output dp_cmd_t      cmd,
  input  wire dp_sts_t sts
);

  ctrl_state_t state, state_next;
  logic        put_pend, put_pend_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      put_pend <= 1'b0;
    end else begin
      state    <= state_next;
      put_pend <= put_pend_next;
    end
  end

  always_comb begin
    state_next    = state;
    put_pend_next = put_pend;
    s_ready       = 1'b0;
    cmd.load_in   = 1'b0;
    cmd.wr_sel    = WR_NONE;
    cmd.rd_sel    = RD_NONE;
    cmd.pos_op    = POS_HOLD;
    cmd.idx_op    = IDX_HOLD;
    cmd.load_out  = 1'b0;

    unique case (state)
      ST_IDLE: begin
        s_ready = 1'b1;
        if (s_valid) begin
          cmd.load_in = 1'b1;
          state_next  = ST_EXEC;
        end
      end

      ST_EXEC: begin
        put_pend_next = 1'b0;
        state_next    = ST_DONE;
        unique case (sts.req)
          REQ_WRITE: begin
            unique case (sts.ch) inside
              CH_NUL, CH_ENQ, CH_BEL, CH_HT, CH_VT, CH_FF: ;
              CH_BS: begin
                if (!sts.col_zero) begin
                  cmd.wr_sel = WR_BLANK_PREV;
                  cmd.pos_op = POS_BACK;
                end
              end
              CH_LF: begin
                cmd.pos_op = POS_CR;
                state_next = ST_NEWLINE;
              end
              CH_CR:  cmd.pos_op = POS_CR;
              CH_DEL: cmd.wr_sel = WR_BLANK_CUR;
              default: begin
                if (sts.col_full) begin
                  // wrap to the next line, then print
                  cmd.pos_op    = POS_WRAP;
                  put_pend_next = 1'b1;
                  state_next    = ST_NEWLINE;
                end else begin
                  cmd.wr_sel = WR_CHAR_CUR;
                  cmd.pos_op = POS_PUT;
                end
              end
            endcase
          end
          REQ_CLEAR: begin
            cmd.idx_op = IDX_ZERO;
            state_next = ST_CLEAR;
          end
          REQ_READ: cmd.rd_sel = RD_OFFSET;
          default: ;
        endcase
      end

      ST_NEWLINE: begin
        if (!sts.last_row) begin
          cmd.pos_op = POS_ROW;
          state_next = put_pend ? ST_PUT : ST_DONE;
        end else begin
          cmd.idx_op = IDX_ZERO;
          state_next = sts.need_copy ? ST_COPY : ST_SCROLL;
        end
      end

      ST_COPY: begin
        cmd.rd_sel = RD_COPY;
        cmd.idx_op = IDX_INC;
        if (sts.idx_last_screen) state_next = ST_COPY_END;
      end

      ST_COPY_END: begin
        cmd.pos_op = POS_REBASE;
        cmd.idx_op = IDX_ZERO;
        state_next = ST_SCROLL;
      end

      ST_SCROLL: begin
        cmd.wr_sel = WR_BLANK_SCROLL;
        cmd.idx_op = IDX_INC;
        if (sts.idx_last_col) begin
          cmd.pos_op = POS_SCROLL;
          state_next = put_pend ? ST_PUT : ST_DONE;
        end
      end

      ST_PUT: begin
        cmd.wr_sel = WR_CHAR_CUR;
        cmd.pos_op = POS_PUT;
        state_next = ST_DONE;
      end

      ST_CLEAR: begin
        cmd.wr_sel = WR_BLANK_IDX;
        cmd.idx_op = IDX_INC;
        if (sts.idx_last_mem) begin
          cmd.pos_op = POS_CLEAR;
          state_next = ST_DONE;
        end
      end

      ST_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          s_ready      = 1'b1;
          if (s_valid) begin
            cmd.load_in = 1'b1;
            state_next  = ST_EXEC;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

### rtl/text_console_char_engine_core.sv
// Text console engine: each transaction on the s_axis side is one request -
// write a character, clear the console or read one video word - and gives
// exactly one transaction on the m_axis side carrying the cursor and screen
// start word offsets after the request. Characters are stored as
// {attribute, character} cells in an internal 16-bit video memory; BS, CR,
// LF, DEL and BEL are acted on, NUL, ENQ, HT, VT and FF are ignored, a line
// past the last column wraps and a line feed on the last row scrolls. Each
// request passes the execute state and then the done state, which loads the
// result once the output is free; a line feed that stays on the screen also
// passes the newline state, and a printable character that wraps passes the
// newline and put states. A scroll blanks the new bottom line, then prints a
// wrapped character if one is pending; near the memory end the screen is
// first copied back to offset 0. Copy and blanking go word by word through
// the one-word-per-cycle memory port; a clear request blanks the whole
// memory, one word written per cycle. Video memory contents are undefined
// after reset until a clear request; no clearing pass runs at reset. The
// result register lets a new request be taken while the previous result
// still waits on m_axis_tready. Configuration writes (cfg_index 0:
// attribute, 1: erase word) must only be issued while the engine is idle.
`timescale 1ns / 1ps
`default_nettype none
`include "text_console_char_engine_core_assert.svh"
module text_console_char_engine_core
  import tcce_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  // Request stream
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,  // char_code[7:0], read_offset[21:8], zero
  input  wire logic [REQ_W-1:0]       s_axis_tuser,  // req_type[1:0]
  input  wire logic                   s_axis_tlast,  // end_of_write
  // Result stream
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic      [OUT_TDATA_W-1:0] m_axis_tdata,  // cursor_offset[13:0],
                                                     // screen_offset[27:14], beep[28],
                                                     // read_data[44:29], zero
  output logic                        m_axis_tlast,  // cursor_publish
  // Configuration
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

  dp_cmd_t           cmd;
  dp_sts_t           sts;
  logic [POS_W-1:0]  out_cursor;
  logic [POS_W-1:0]  out_screen;
  logic              out_beep;
  logic [CELL_W-1:0] out_rdata;

  // Sequencer: decode the request and walk rows or memory as needed
  tcce_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_axis_tvalid),
    .s_ready (s_axis_tready),
    .cmd     (cmd),
    .sts     (sts)
  );

  // Positions, video memory, configuration and result register
  tcce_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .in_req      (s_axis_tuser),
    .in_ch       (s_axis_tdata[7:0]),
    .in_roff     (s_axis_tdata[21:8]),
    .in_eow      (s_axis_tlast),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .out_ready   (m_axis_tready),
    .out_valid   (m_axis_tvalid),
    .out_cursor  (out_cursor),
    .out_screen  (out_screen),
    .out_publish (m_axis_tlast),
    .out_beep    (out_beep),
    .out_rdata   (out_rdata)
  );

  // Pack the result fields from the lowest bit up; pad to whole bytes
  assign m_axis_tdata = {3'b000, out_rdata, out_beep, out_screen, out_cursor};

  // The copy pipeline owns the write port for the cycle after each copy read
  `TCCE_ASSERT_IMPLIES(a_copy_write_port, sts.copy_pend, cmd.wr_sel == WR_NONE,
                       "memory write issued while a copy write is pending")

  // A result is only loaded when the result register can take it
  `TCCE_ASSERT_IMPLIES(a_result_load_free, cmd.load_out, sts.out_free,
                       "result loaded over an untaken result")

  // Column never runs past the wrap point, row stays on the screen
  `TCCE_ASSERT_ALWAYS(a_position_bounds,
                      (sts.column <= COL_W'(COLUMNS)) && (sts.row < ROW_W'(ROWS)),
                      "column or row out of range")

endmodule
`default_nettype wire
